// ===== hw/rtl/ssc_pkg.sv =====
// Shared types and constants for the sphere-sphere contact pipeline.
// Used by sscu_isqrt, sscu_div and sphere_sphere_contact_unit; no dependencies.
package ssc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W       = 32;
	localparam int RAD_W         = 30;
	localparam int ABS_W         = 31;
	localparam int NORM_W        = 18;
	localparam int NORM_MAG_W    = 17;
	localparam int DEPTH_W       = 31;
	localparam int SQ_W          = 64;
	localparam int ROOT_W        = 32;
	localparam logic [NORM_MAG_W-1:0] NORM_MAX = 17'h1FFFF;

	// Per-item information that travels alongside the arithmetic.
	typedef struct packed {
		logic [2:0][COORD_W-1:0] a;
		logic [2:0][ABS_W-1:0]   ad;
		logic [2:0]              neg;
		logic [RAD_W-1:0]        ra;
		logic [DEPTH_W-1:0]      rsum;
		logic                    far;
		logic                    hit;
		logic                    dzero;
		logic [DEPTH_W-1:0]      depth;
	} ctx_t;

endpackage

// ===== hw/rtl/sscu_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on ssc_pkg for the operand and root widths.
module sscu_isqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [ssc_pkg::SQ_W-1:0]  sq,
	output logic [ssc_pkg::ROOT_W-1:0] root
);
	import ssc_pkg::*;

	localparam int STEPS = ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	logic [REM_W-1:0]  rem_s  [STEPS];
	logic [ROOT_W-1:0] root_s [STEPS];
	logic [SQ_W-1:0]   rad_s  [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [SQ_W-1:0]   rad_in;
		logic [REM_W+1:0]  trial_rem;
		logic [REM_W+1:0]  trial_sub;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = sq;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
		end

		// Bring down the next pair of radicand bits and try the digit one.
		assign trial_rem = {rem_in, rad_in[SQ_W-1 -: 2]};
		assign trial_sub = (REM_W+2)'({root_in, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= {rad_in[SQ_W-3:0], 2'b00};
				if (trial_rem >= trial_sub) begin
					rem_s[k]  <= REM_W'(trial_rem - trial_sub);
					root_s[k] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k]  <= REM_W'(trial_rem);
					root_s[k] <= {root_in[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[STEPS-1];

endmodule

// ===== hw/rtl/sscu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ssc_pkg for the divisor width.
module sscu_div #(
	parameter int FRAC_BITS = ssc_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [32+FRAC_BITS-1:0]     num,
	input  logic [ssc_pkg::ROOT_W-1:0]  den,
	output logic [FRAC_BITS+1:0]        quo
);
	import ssc_pkg::*;

	localparam int QW    = FRAC_BITS + 2;
	localparam int NUM_W = 32 + FRAC_BITS;
	localparam int RW    = ROOT_W + QW;

	logic [RW-1:0]     rem_s [QW];
	logic [ROOT_W-1:0] den_s [QW];
	logic [QW-1:0]     quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [RW-1:0]     rem_in;
		logic [ROOT_W-1:0] den_in;
		logic [QW-1:0]     quo_in;
		logic [RW-1:0]     shifted;

		if (k == 0) begin : g_first
			assign rem_in = RW'(num);
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign shifted = RW'(den_in) << (QW - 1 - k);

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_in;
				if (rem_in >= shifted) begin
					rem_s[k] <= rem_in - shifted;
					quo_s[k] <= quo_in | (QW'(1) << (QW - 1 - k));
				end else begin
					rem_s[k] <= rem_in;
					quo_s[k] <= quo_in;
				end
			end
		end
	end

	logic unused_num_w;
	assign unused_num_w = (NUM_W > 0) ? 1'b0 : 1'b1;
	assign quo = quo_s[QW-1] | {QW{unused_num_w}};

endmodule

// ===== hw/rtl/sphere_sphere_contact_unit.sv =====
// Top level of the sphere-sphere contact pipeline.
// Depends on ssc_pkg, sscu_isqrt and sscu_div.
//
// Takes one sphere pair per clock while in_stall is low and returns one result
// per pair, in order. Registered steps, in order: the difference, the squares,
// the sum, the square-root stages, the hit test, the division stages, the normal
// product and the contact sum. The whole pipeline holds while out_stall keeps a
// finished result waiting; in_stall is high only then.
module sphere_sphere_contact_unit #(
	parameter int FRAC_BITS = ssc_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [ssc_pkg::COORD_W-1:0] first_x,
	input  logic signed [ssc_pkg::COORD_W-1:0] first_y,
	input  logic signed [ssc_pkg::COORD_W-1:0] first_z,
	input  logic signed [ssc_pkg::COORD_W-1:0] second_x,
	input  logic signed [ssc_pkg::COORD_W-1:0] second_y,
	input  logic signed [ssc_pkg::COORD_W-1:0] second_z,
	input  logic [ssc_pkg::RAD_W-1:0]          radius_first,
	input  logic [ssc_pkg::RAD_W-1:0]          radius_second,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic signed [ssc_pkg::NORM_W-1:0]  normal_x,
	output logic signed [ssc_pkg::NORM_W-1:0]  normal_y,
	output logic signed [ssc_pkg::NORM_W-1:0]  normal_z,
	output logic [ssc_pkg::DEPTH_W-1:0]        depth,
	output logic signed [ssc_pkg::COORD_W-1:0] contact_x,
	output logic signed [ssc_pkg::COORD_W-1:0] contact_y,
	output logic signed [ssc_pkg::COORD_W-1:0] contact_z
);
	import ssc_pkg::*;

	localparam int QW       = FRAC_BITS + 2;
	localparam int NUM_W    = 32 + FRAC_BITS;
	localparam int ROOT_STG = 3 + ROOT_W - 1;
	localparam int HIT_STG  = ROOT_STG + 1;
	localparam int DIV_STG  = HIT_STG + QW;
	localparam int MUL_STG  = DIV_STG + 1;
	localparam int OUT_STG  = MUL_STG + 1;
	localparam int PROD_W   = NORM_MAG_W + RAD_W;
	localparam int SUM_W    = PROD_W + 2;

	logic en;
	logic [OUT_STG:0] v_s;
	ctx_t ctx_s [MUL_STG+1];

	assign en        = !v_s[OUT_STG] || !out_stall;
	assign in_stall  = !en;
	assign out_valid = v_s[OUT_STG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[OUT_STG-1:0], in_valid};
		end
	end

	// Stage 1: centre difference, magnitude and sign.
	logic [2:0][COORD_W-1:0] a_in;
	logic [2:0][COORD_W-1:0] b_in;
	ctx_t ctx_in;

	assign a_in = {first_z, first_y, first_x};
	assign b_in = {second_z, second_y, second_x};

	always_comb begin
		logic signed [COORD_W:0] d;
		logic [COORD_W:0] mag;
		ctx_in = '0;
		for (int i = 0; i < 3; i++) begin
			d   = $signed({b_in[i][COORD_W-1], b_in[i]}) - $signed({a_in[i][COORD_W-1], a_in[i]});
			mag = d[COORD_W] ? (COORD_W+1)'(0) - d : d;
			ctx_in.a[i]   = a_in[i];
			ctx_in.ad[i]  = mag[ABS_W-1:0];
			ctx_in.neg[i] = d[COORD_W];
			if (mag[COORD_W:ABS_W] != 2'b00) begin
				ctx_in.far = 1'b1;
			end
		end
		ctx_in.ra   = radius_first;
		ctx_in.rsum = DEPTH_W'(radius_first) + DEPTH_W'(radius_second);
	end

	// Context shift line; the hit stage fills in the decision fields.
	logic [ROOT_W-1:0] root;
	logic [ROOT_W-1:0] len_s;
	logic [2:0][NUM_W-1:0] num_s;
	ctx_t ctx_hit;

	always_comb begin
		ctx_hit       = ctx_s[HIT_STG-1];
		ctx_hit.hit   = !ctx_s[HIT_STG-1].far && (root < ROOT_W'(ctx_s[HIT_STG-1].rsum));
		ctx_hit.dzero = (root == '0);
		ctx_hit.depth = DEPTH_W'(ROOT_W'(ctx_s[HIT_STG-1].rsum) - root);
	end

	for (genvar k = 0; k <= MUL_STG; k++) begin : g_ctx
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					ctx_s[k] <= ctx_in;
				end
			end
		end else if (k == HIT_STG) begin : g_hit
			always_ff @(posedge clk) begin
				if (en) begin
					ctx_s[k] <= ctx_hit;
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					ctx_s[k] <= ctx_s[k-1];
				end
			end
		end
	end

	// Stages 2 and 3: squares, then their sum.
	logic [2:0][2*ABS_W-1:0] sqr_s2;
	logic [SQ_W-1:0] sq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sqr_s2[i] <= ctx_s[0].ad[i] * ctx_s[0].ad[i];
			end
			sq_s3 <= SQ_W'(sqr_s2[0]) + SQ_W'(sqr_s2[1]) + SQ_W'(sqr_s2[2]);
		end
	end

	sscu_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.sq   (sq_s3),
		.root (root)
	);

	// Hit stage: divisor and rounded numerators for the normal.
	always_ff @(posedge clk) begin
		if (en) begin
			len_s <= root;
			for (int i = 0; i < 3; i++) begin
				num_s[i] <= (NUM_W'(ctx_s[HIT_STG-1].ad[i]) << FRAC_BITS)
					+ NUM_W'(root >> 1);
			end
		end
	end

	logic [2:0][QW-1:0] quo;

	for (genvar i = 0; i < 3; i++) begin : g_div
		sscu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk (clk),
			.en  (en),
			.num (num_s[i]),
			.den (len_s),
			.quo (quo[i])
		);
	end

	// Normal magnitude with saturation, then its product with radius A.
	logic [2:0][NORM_MAG_W-1:0] nm_s;
	logic [2:0][PROD_W-1:0]     prod_s;

	always_comb begin
		logic [QW+NORM_MAG_W-1:0] q_ext;
		for (int i = 0; i < 3; i++) begin
			q_ext = (QW+NORM_MAG_W)'(quo[i]);
			if (ctx_s[DIV_STG].dzero) begin
				nm_s[i] = '0;
			end else if (q_ext > (QW+NORM_MAG_W)'(NORM_MAX)) begin
				nm_s[i] = NORM_MAX;
			end else begin
				nm_s[i] = q_ext[NORM_MAG_W-1:0];
			end
		end
	end

	logic [2:0][NORM_MAG_W-1:0] nm_m_s;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nm_m_s[i] <= nm_s[i];
				prod_s[i] <= PROD_W'(nm_s[i]) * PROD_W'(ctx_s[DIV_STG].ra);
			end
		end
	end

	// Output stage: signed normal, rounded offset and saturated contact point.
	logic signed [2:0][COORD_W-1:0] cpt;
	logic signed [2:0][NORM_W-1:0]  nrm;

	always_comb begin
		logic [PROD_W-1:0] om;
		logic signed [SUM_W-1:0] c;
		for (int i = 0; i < 3; i++) begin
			om = (prod_s[i] + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
			if (ctx_s[MUL_STG].neg[i]) begin
				c      = SUM_W'($signed(ctx_s[MUL_STG].a[i])) - $signed(SUM_W'(om));
				nrm[i] = NORM_W'(0) - NORM_W'(nm_m_s[i]);
			end else begin
				c      = SUM_W'($signed(ctx_s[MUL_STG].a[i])) + $signed(SUM_W'(om));
				nrm[i] = NORM_W'(nm_m_s[i]);
			end
			if (c > $signed(SUM_W'(32'h7FFF_FFFF))) begin
				cpt[i] = 32'h7FFF_FFFF;
			end else if (c < -$signed(SUM_W'(32'h8000_0000))) begin
				cpt[i] = 32'h8000_0000;
			end else begin
				cpt[i] = c[COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctx_s[MUL_STG].hit) begin
				hit       <= 1'b1;
				depth     <= ctx_s[MUL_STG].depth;
				normal_x  <= nrm[0];
				normal_y  <= nrm[1];
				normal_z  <= nrm[2];
				contact_x <= cpt[0];
				contact_y <= cpt[1];
				contact_z <= cpt[2];
			end else begin
				hit       <= 1'b0;
				depth     <= '0;
				normal_x  <= '0;
				normal_y  <= '0;
				normal_z  <= '0;
				contact_x <= '0;
				contact_y <= '0;
				contact_z <= '0;
			end
		end
	end

`ifndef SYNTH
	// A miss carries no geometry.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> depth == '0 && normal_x == '0 && normal_y == '0
			&& normal_z == '0 && contact_x == '0 && contact_y == '0 && contact_z == '0)
		else $error("miss result carries nonzero fields");

	// A hit always has the distance strictly inside the radius sum.
	a_hit_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> depth != '0)
		else $error("hit with zero depth");

	// Normal components never reach the most negative code.
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> normal_x != 18'h20000 && normal_y != 18'h20000
			&& normal_z != 18'h20000)
		else $error("normal out of range");

	// The pipeline freezes while the output is held.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s))
		else $error("pipeline moved while stalled");
`endif

endmodule

// ===== tb/tb_sphere_sphere_contact_unit.sv =====
// Self-checking testbench for sphere_sphere_contact_unit: random and directed sphere pairs.
// Depends on ssc_pkg and the RTL of the contact pipeline; predicts each result internally.
`timescale 1ns / 100ps

module tb_sphere_sphere_contact_unit;
	import ssc_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = FB + 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1550;

	typedef struct {
		logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz;
		logic [RAD_W-1:0]          ra, rb;
	} pair_t;

	typedef struct {
		logic                      hit;
		logic signed [NORM_W-1:0]  nx, ny, nz;
		logic [DEPTH_W-1:0]        depth;
		logic signed [COORD_W-1:0] cx, cy, cz;
	} contact_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [COORD_W-1:0] first_x, first_y, first_z, second_x, second_y, second_z;
	logic [RAD_W-1:0] radius_first, radius_second;
	logic hit;
	logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
	logic [DEPTH_W-1:0] depth;
	logic signed [COORD_W-1:0] contact_x, contact_y, contact_z;

	pair_t    pending_pairs[$];
	contact_t expected_contacts[$];
	int  mismatches = 0;
	int  idle_cycles = 0;
	bit  stimulus_done = 0;
	bit  hold_sender = 0;
	bit  quiet_stretch = 0;
	bit  in_taken = 0;

	sphere_sphere_contact_unit dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] root_floor(input logic [63:0] s);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic contact_t predict_contact(input pair_t p);
		contact_t r;
		longint a[3], d[3], c;
		logic [63:0] ad[3], sq, span, rsum, nm, om;
		bit far;
		a[0] = p.ax; a[1] = p.ay; a[2] = p.az;
		d[0] = longint'(p.bx) - a[0];
		d[1] = longint'(p.by) - a[1];
		d[2] = longint'(p.bz) - a[2];
		r = '{default: 0};
		far = 0;
		sq = 0;
		rsum = 64'(p.ra) + 64'(p.rb);
		for (int i = 0; i < 3; i++) begin
			ad[i] = d[i] < 0 ? -d[i] : d[i];
			if (ad[i] >= 64'h8000_0000) far = 1;
		end
		if (far) return r;
		for (int i = 0; i < 3; i++) sq += ad[i] * ad[i];
		span = root_floor(sq);
		if (span >= rsum) return r;
		r.hit = 1;
		r.depth = DEPTH_W'(rsum - span);
		for (int i = 0; i < 3; i++) begin
			nm = 0;
			if (span != 0) begin
				nm = ((ad[i] << FB) + span / 2) / span;
				if (nm > 131071) nm = 131071;
			end
			om = (nm * 64'(p.ra) + (64'd1 << (FB - 1))) >> FB;
			c = d[i] < 0 ? a[i] - longint'(om) : a[i] + longint'(om);
			if (c > 64'sh7FFF_FFFF) c = 64'sh7FFF_FFFF;
			if (c < -64'sh8000_0000) c = -64'sh8000_0000;
			case (i)
				0: begin r.nx = d[i] < 0 ? -NORM_W'(nm) : NORM_W'(nm); r.cx = c[31:0]; end
				1: begin r.ny = d[i] < 0 ? -NORM_W'(nm) : NORM_W'(nm); r.cy = c[31:0]; end
				default: begin r.nz = d[i] < 0 ? -NORM_W'(nm) : NORM_W'(nm); r.cz = c[31:0]; end
			endcase
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_coord(input int spread);
		case (spread)
			0: return $urandom;
			1: return $urandom_range(0, 32'h0000_FFFF) - 32'h0000_8000;
			2: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
			default: return $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
		endcase
	endfunction

	task automatic push_pair(input logic [31:0] ax, ay, az, bx, by, bz,
			input logic [29:0] ra, rb);
		pair_t p;
		p.ax = ax; p.ay = ay; p.az = az;
		p.bx = bx; p.by = by; p.bz = bz;
		p.ra = ra; p.rb = rb;
		pending_pairs = {pending_pairs, p};
	endtask

	// Stimulus: directed corners first, then random pairs mostly near contact.
	initial begin
		logic [31:0] ax, ay, az, ox, oy, oz;
		logic [29:0] ra, rb;
		int spread;
		push_pair(0, 0, 0, 0, 0, 0, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
		push_pair(0, 0, 0, 0, 0, 0, 0, 0);
		push_pair(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
		push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 30'h1, 0);
		push_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 0, 30'h1);
		push_pair(32'h7FFF_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
		push_pair(32'h8001_0000, 0, 0, 32'h8000_0000, 0, 0, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
		push_pair(0, 0, 0, 32'h0002_0000, 0, 0, 30'h1_0000, 30'h1_0000);
		push_pair(0, 0, 0, 32'h0002_0000, 0, 0, 30'h1_0000, 30'h1_0001);
		push_pair(0, 0, 0, 0, 32'hFFFF_0000, 0, 30'h1_0000, 30'h1_0000);
		push_pair(0, 0, 0, 32'h1000, 32'hFFFF_F000, 32'h1000, 30'h3FFF_FFFF, 0);
		push_pair(32'h4000_0000, 32'hC000_0000, 0, 32'hC000_0001, 32'h3FFF_FFFF, 0,
			30'h3FFF_FFFF, 30'h3FFF_FFFF);
		push_pair(0, 0, 0, 0, 0, 32'h3, 0, 30'h3FFF_FFFF);
		push_pair(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFE, 0, 0, 30'h3FFF_FFFF, 0);
		push_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5556,
			32'hAAAA_AAAA, 32'h5555_5555, 30'h2AAA_AAAA, 30'h1555_5555);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			spread = $urandom_range(0, 3);
			ax = rand_coord(0); ay = rand_coord(0); az = rand_coord(0);
			ra = 30'($urandom); rb = 30'($urandom);
			if ($urandom_range(0, 9) < 8) begin
				// Offsets near the radius scale so that most pairs touch.
				ox = rand_coord(spread); oy = rand_coord(spread); oz = rand_coord(spread);
				if (spread == 1) begin
					ra = 30'($urandom_range(0, 32'hFFFF));
					rb = 30'($urandom_range(0, 32'hFFFF));
				end else if (spread == 2) begin
					ra = 30'($urandom_range(0, 32'hFF_FFFF));
					rb = 30'($urandom_range(0, 32'hFF_FFFF));
				end
				if ($urandom_range(0, 19) == 0) begin ox = 0; oy = 0; oz = 0; end
				push_pair(ax, ay, az, ax + ox, ay + oy, az + oz, ra, rb);
			end else begin
				push_pair(ax, ay, az, rand_coord(0), rand_coord(0), rand_coord(0), ra, rb);
			end
		end
		stimulus_done = 1;
	end

	// Driver: presents pairs at the falling edge; a payload not yet taken is held.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!in_valid || in_taken) begin
			if (pending_pairs.size() != 0 && !hold_sender
					&& (quiet_stretch || $urandom_range(0, 99) >= 14)) begin
				pair_t p;
				p = pending_pairs.pop_front();
				first_x <= p.ax; first_y <= p.ay; first_z <= p.az;
				second_x <= p.bx; second_y <= p.by; second_z <= p.bz;
				radius_first <= p.ra; radius_second <= p.rb;
				expected_contacts = {expected_contacts, predict_contact(p)};
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) out_stall <= 0;
		else out_stall <= quiet_stretch ? 1'b0 : ($urandom_range(0, 99) < 14);
	end

	// Monitor: compares each result transaction with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && !out_stall) begin
				if (expected_contacts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result transaction");
				end else begin
					contact_t e;
					e = expected_contacts.pop_front();
					if (hit !== e.hit || normal_x !== e.nx || normal_y !== e.ny
							|| normal_z !== e.nz || depth !== e.depth || contact_x !== e.cx
							|| contact_y !== e.cy || contact_z !== e.cz) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp hit %0d n %0d %0d %0d depth %0d c %0d %0d %0d; got hit %0d n %0d %0d %0d depth %0d c %0d %0d %0d",
								e.hit, e.nx, e.ny, e.nz, e.depth, e.cx, e.cy, e.cz,
								hit, normal_x, normal_y, normal_z, depth,
								contact_x, contact_y, contact_z);
					end
				end
			end
		end
	end

	// Sequencing: reset, a drain pause, a stretch without idling, then the end.
	initial begin
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		{first_x, first_y, first_z, second_x, second_y, second_z} = '0;
		radius_first = 0;
		radius_second = 0;
		repeat (12) @(posedge clk);
		arst_n = 1;
		wait (pending_pairs.size() < RANDOM_ITEMS - 200);
		@(negedge clk) hold_sender = 1;
		wait (expected_contacts.size() == 0 && !in_valid);
		@(negedge clk) hold_sender = 0;
		wait (pending_pairs.size() < RANDOM_ITEMS - 600);
		quiet_stretch = 1;
		wait (pending_pairs.size() < RANDOM_ITEMS - 900);
		quiet_stretch = 0;
		wait (stimulus_done && pending_pairs.size() == 0 && expected_contacts.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_contacts.size() == 0)
			$display("PASS sphere_sphere_contact_unit");
		else
			$display("FAIL sphere_sphere_contact_unit");
		$finish;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL sphere_sphere_contact_unit");
			$finish;
		end
	end

endmodule
